// ----- rtl/iphc_pkg.sv -----
// shared types and constants for the ip packet header classifier
// no dependencies; imported by every rtl module and by the checker
package iphc_pkg;

  localparam int MAX_PACKET_BYTES = 65535;

  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] IPV6_VERSION = 4'd6;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [5:0] IPV6_HDR_BYTES  = 6'd40;
  localparam logic [6:0] PORT_HDR_BYTES  = 7'd8;

  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
  localparam logic [15:0] PORT_DHCP_CLI = 16'd68;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_NTP      = 16'd123;

  typedef enum logic [2:0] {
    NET_IPV4   = 3'd0,
    NET_ICMP   = 3'd1,
    NET_IPV6   = 3'd2,
    NET_ICMPV6 = 3'd3,
    NET_OTHER  = 3'd4
  } net_class_e;

  typedef enum logic [1:0] {
    TRANS_NONE = 2'd0,
    TRANS_TCP  = 2'd1,
    TRANS_UDP  = 2'd2
  } trans_class_e;

  typedef enum logic [2:0] {
    APP_HTTP  = 3'd0,
    APP_DHCP  = 3'd1,
    APP_DNS   = 3'd2,
    APP_NTP   = 3'd3,
    APP_OTHER = 3'd4,
    APP_NA    = 3'd5
  } app_class_e;

  // per-packet header captures
  typedef struct packed {
    logic [3:0]  version;
    logic [5:0]  offset;
    logic [7:0]  proto;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [31:0] thead;
  } cap_t;

  // one classification result
  typedef struct packed {
    net_class_e   net_class;
    logic [7:0]   next_protocol;
    logic [63:0]  source_high;
    logic [63:0]  source_low;
    logic [63:0]  dest_high;
    logic [63:0]  dest_low;
    logic [15:0]  icmp_type_code;
    trans_class_e transport_class;
    logic [15:0]  source_port;
    logic [15:0]  dest_port;
    app_class_e   app_class;
    logic [15:0]  packet_length;
  } res_t;

  // handshake view of the input register
  typedef struct packed {
    logic       valid;
    logic       take;
    logic [7:0] data;
    logic       last;
  } stage_t;

endpackage

// ----- rtl/ip_packet_header_classifier_core.sv -----
// ip packet header classifier: one byte per cycle in while not stalled, one result per packet out
// result path: the last byte waits in the byte register until the result register
//   is free, then loads the result register, which raises out_valid_o
// throughput: one byte per cycle; the byte register and the result register
//   are separate, so bytes keep flowing while a result waits to be taken; only
//   a last byte waits in the byte register while the result register is full
// reset: rst_ni asynchronous active low; clears the byte position, all header
//   captures and both valid flags
module ip_packet_header_classifier_core
  import iphc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // one classification per packet
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  net_class_o,
  output logic [7:0]  next_protocol_o,
  output logic [63:0] source_high_o,
  output logic [63:0] source_low_o,
  output logic [63:0] dest_high_o,
  output logic [63:0] dest_low_o,
  output logic [15:0] icmp_type_code_o,
  output logic [1:0]  transport_class_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [2:0]  app_class_o,
  output logic [15:0] packet_length_o
);

  stage_t      stage;
  cap_t        view;
  logic [15:0] pos;
  res_t        res;
  res_t        res_q;
  logic        out_valid_q, out_valid_d;
  logic        out_ready;
  logic        load;

  // result register is free when empty or being taken this cycle
  assign out_ready = !out_valid_q || !out_stall_i;

  // input register stage
  iphc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_ready_i (out_ready),
    .stage_o     (stage)
  );

  // header capture, updated once per processed byte
  iphc_capture u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .view_o  (view),
    .pos_o   (pos)
  );

  // classification of the view including the current byte
  iphc_classify u_classify (
    .cap_i (view),
    .pos_i (pos),
    .res_o (res)
  );

  // only the last byte of a packet loads the result register
  assign load = stage.take && stage.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds while stalled because load requires out_ready
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign net_class_o       = res_q.net_class;
  assign next_protocol_o   = res_q.next_protocol;
  assign source_high_o     = res_q.source_high;
  assign source_low_o      = res_q.source_low;
  assign dest_high_o       = res_q.dest_high;
  assign dest_low_o        = res_q.dest_low;
  assign icmp_type_code_o  = res_q.icmp_type_code;
  assign transport_class_o = res_q.transport_class;
  assign source_port_o     = res_q.source_port;
  assign dest_port_o       = res_q.dest_port;
  assign app_class_o       = res_q.app_class;
  assign packet_length_o   = res_q.packet_length;

endmodule

// ----- rtl/iphc_in_stage.sv -----
// input register of the classifier: holds one accepted byte until processed
// depends on iphc_pkg
module iphc_in_stage
  import iphc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_ready_i,
  output stage_t     stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       take;
  logic       accept;

  // a non-last byte never waits for the output register
  assign take       = valid_q && (!last_q || out_ready_i);
  assign in_stall_o = valid_q && !take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.take  = take;
  assign stage_o.data  = data_q;
  assign stage_o.last  = last_q;

endmodule

// ----- rtl/iphc_capture.sv -----
// per-packet header capture: byte counter, version, offsets, addresses, ports
// depends on iphc_pkg
module iphc_capture
  import iphc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_t      stage_i,
  output cap_t        view_o,
  output logic [15:0] pos_o
);

  cap_t        cap_q, cap_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  b;
  logic [63:0] th_wide;

  // drop byte b into lanes of r, big-endian over [first, first+len)
  function automatic logic [63:0] place_bytes(input logic [63:0] r,
                                              input logic [15:0] pos,
                                              input logic [15:0] first,
                                              input logic [3:0]  len,
                                              input logic [7:0]  bv);
    logic [63:0] res;
    res = r;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < len) && (pos == first + 16'(len) - 16'd1 - 16'(i))) begin
        res[8*i +: 8] = bv;
      end
    end
    return res;
  endfunction

  assign b = stage_i.data;

  always_comb begin
    cap_d = cap_q;
    th_wide = '0;
    // version and header length come from the first byte itself
    if (pos_q == 16'd0) begin
      cap_d.version = b[7:4];
      if (b[7:4] == IPV4_VERSION) begin
        cap_d.offset = {b[3:0], 2'b00};
      end else if (b[7:4] == IPV6_VERSION) begin
        cap_d.offset = IPV6_HDR_BYTES;
      end else begin
        cap_d.offset = '0;
      end
    end
    if (cap_d.version == IPV4_VERSION) begin
      if (pos_q == 16'd9) begin
        cap_d.proto = b;
      end
      cap_d.src_low = place_bytes(cap_q.src_low, pos_q, 16'd12, 4'd4, b);
      cap_d.dst_low = place_bytes(cap_q.dst_low, pos_q, 16'd16, 4'd4, b);
    end else if (cap_d.version == IPV6_VERSION) begin
      if (pos_q == 16'd6) begin
        cap_d.proto = b;
      end
      cap_d.src_high = place_bytes(cap_q.src_high, pos_q, 16'd8, 4'd8, b);
      cap_d.src_low  = place_bytes(cap_q.src_low, pos_q, 16'd16, 4'd8, b);
      cap_d.dst_high = place_bytes(cap_q.dst_high, pos_q, 16'd24, 4'd8, b);
      cap_d.dst_low  = place_bytes(cap_q.dst_low, pos_q, 16'd32, 4'd8, b);
    end
    if ((cap_d.version == IPV4_VERSION) || (cap_d.version == IPV6_VERSION)) begin
      th_wide = place_bytes({32'd0, cap_q.thead}, pos_q, {10'd0, cap_d.offset}, 4'd4, b);
      cap_d.thead = th_wide[31:0];
    end
    pos_d = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
      pos_q <= '0;
    end else if (stage_i.take) begin
      if (stage_i.last) begin
        cap_q <= '0;
        pos_q <= '0;
      end else begin
        cap_q <= cap_d;
        pos_q <= pos_d;
      end
    end
  end

  assign view_o = cap_d;
  assign pos_o  = pos_q;

endmodule

// ----- rtl/iphc_classify.sv -----
// classification of a finished packet from its header captures
// depends on iphc_pkg; pure combinational
module iphc_classify
  import iphc_pkg::*;
(
  input  cap_t        cap_i,
  input  logic [15:0] pos_i,
  output res_t        res_o
);

  logic [16:0] n;
  logic        v4, v6_ok, tr_ok;
  logic [15:0] sport, dport, port;

  assign n     = {1'b0, pos_i} + 17'd1;
  assign v4    = (cap_i.version == IPV4_VERSION);
  assign v6_ok = (cap_i.version == IPV6_VERSION) && (n >= 17'(IPV6_HDR_BYTES));
  assign tr_ok = (n >= 17'(cap_i.offset) + 17'(PORT_HDR_BYTES));
  assign sport = cap_i.thead[31:16];
  assign dport = cap_i.thead[15:0];
  assign port  = (sport != 16'd0) ? sport : dport;

  always_comb begin
    res_o = '0;
    res_o.net_class = NET_OTHER;
    res_o.transport_class = TRANS_NONE;
    res_o.app_class = APP_NA;
    res_o.packet_length = (n > 17'(MAX_PACKET_BYTES)) ? 16'(MAX_PACKET_BYTES) : n[15:0];
    if (v4 || v6_ok) begin
      res_o.next_protocol = cap_i.proto;
      res_o.source_high   = cap_i.src_high;
      res_o.source_low    = cap_i.src_low;
      res_o.dest_high     = cap_i.dst_high;
      res_o.dest_low      = cap_i.dst_low;
      if (v4) begin
        if (cap_i.proto == PROTO_ICMP) begin
          res_o.net_class      = NET_ICMP;
          res_o.icmp_type_code = sport;
        end else begin
          res_o.net_class = NET_IPV4;
        end
      end else begin
        res_o.net_class = (cap_i.proto == PROTO_ICMPV6) ? NET_ICMPV6 : NET_IPV6;
      end
      if (((cap_i.proto == PROTO_TCP) || (cap_i.proto == PROTO_UDP)) && tr_ok) begin
        res_o.transport_class = (cap_i.proto == PROTO_TCP) ? TRANS_TCP : TRANS_UDP;
        res_o.source_port = sport;
        res_o.dest_port   = dport;
        case (port)
          PORT_HTTP, PORT_HTTPS:        res_o.app_class = APP_HTTP;
          PORT_DHCP_SRV, PORT_DHCP_CLI: res_o.app_class = APP_DHCP;
          PORT_DNS:                     res_o.app_class = APP_DNS;
          PORT_NTP:                     res_o.app_class = APP_NTP;
          default:                      res_o.app_class = APP_OTHER;
        endcase
      end
    end
  end

endmodule

// ----- rtl/iphc_checker.sv -----
// port-level checks for the classifier, attached to the top level by bind
// depends on iphc_pkg and ip_packet_header_classifier_core
module iphc_checker
  import iphc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  net_class_o,
  input logic [7:0]  next_protocol_o,
  input logic [63:0] source_low_o,
  input logic [63:0] dest_low_o,
  input logic [15:0] icmp_type_code_o,
  input logic [1:0]  transport_class_o,
  input logic [15:0] source_port_o,
  input logic [15:0] dest_port_o,
  input logic [2:0]  app_class_o,
  input logic [15:0] packet_length_o
);

  // a stalled result stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packet_length_o)
      && $stable(source_low_o) && $stable(app_class_o))
    else $error("stalled result changed");

  // no transport means no ports and no application class
  a_no_transport: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transport_class_o == TRANS_NONE) |->
      (app_class_o == APP_NA) && (source_port_o == 16'd0) && (dest_port_o == 16'd0))
    else $error("ports or app class without transport");

  // icmp type and code appear only for icmp over ipv4
  a_icmp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (net_class_o != NET_ICMP) |-> icmp_type_code_o == 16'd0)
    else $error("icmp field set for non-icmp packet");

  // unknown versions or short ipv6 packets carry no header captures
  a_other_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (net_class_o == NET_OTHER) |->
      (next_protocol_o == 8'd0) && (source_low_o == 64'd0) && (dest_low_o == 64'd0)
      && (transport_class_o == TRANS_NONE) && (packet_length_o != 16'd0))
    else $error("class other with captured header fields");

endmodule

bind ip_packet_header_classifier_core iphc_checker u_iphc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .net_class_o       (net_class_o),
  .next_protocol_o   (next_protocol_o),
  .source_low_o      (source_low_o),
  .dest_low_o        (dest_low_o),
  .icmp_type_code_o  (icmp_type_code_o),
  .transport_class_o (transport_class_o),
  .source_port_o     (source_port_o),
  .dest_port_o       (dest_port_o),
  .app_class_o       (app_class_o),
  .packet_length_o   (packet_length_o)
);
